// File: hdl/bpb_pkg.sv
// Shared types, action codes and constants of the bit packing buffer.
package bpb_pkg;

  localparam int BUFFER_BYTES_DEF = 8192;
  localparam int MAX_FIELD_BITS   = 64;
  localparam int SLICE_MAX        = 64;
  localparam int CAP_W            = 14;
  localparam int POS_W            = 17;
  localparam int LEN_W            = 7;
  localparam int WIN_BYTES        = 9;
  localparam int WIN_W            = 8 * WIN_BYTES;
  localparam int CNT_W            = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 14'd8192;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_GET    = 2'd2;
  localparam logic [1:0] ACT_SLICE  = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [63:0]      value;
    logic [LEN_W-1:0] width;
    logic             bit_value;
    logic [15:0]      bit_pos;
    logic [POS_W-1:0] slice_end;
  } bpb_item_t;

  typedef struct packed {
    logic [63:0]      read_value;
    logic             bit_out;
    logic [POS_W-1:0] fill_out;
    logic             error;
  } bpb_result_t;

endpackage

// File: hdl/bpb_if.sv
// Valid/ready channel interfaces for request and result beats.
interface bpb_item_if;
  import bpb_pkg::*;
  logic      valid;
  logic      ready;
  bpb_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpb_result_if;
  import bpb_pkg::*;
  logic        valid;
  logic        ready;
  bpb_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/bpb_mem.sv
// Byte-wide synchronous store: one write port, one registered read port.
module bpb_mem #(
  parameter int DEPTH = bpb_pkg::BUFFER_BYTES_DEF,
  parameter int AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bpb_engine.sv
// Request sequencer: store clear after reset, range checks, byte read-modify-write, slice gather, fill.
module bpb_engine #(
  parameter int BUFFER_BYTES = bpb_pkg::BUFFER_BYTES_DEF,
  parameter int AW           = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  output logic                           item_ready_o,
  input  bpb_pkg::bpb_item_t             item_i,
  input  logic [bpb_pkg::POS_W-1:0]      limit_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output bpb_pkg::bpb_result_t           res_o,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [7:0]                     mem_wdata_o,
  output logic                           mem_re_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [7:0]                     mem_rdata_i
);
  import bpb_pkg::*;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] pj_q, pj_d;
  logic             pend_q, pend_d;
  logic [POS_W-1:0] fill_q, fill_d;

  bpb_item_t        it_q;
  logic             err_q;
  logic [CAP_W-1:0] first_q;
  logic [CNT_W-1:0] nbytes_q;
  logic [2:0]       off_q;
  logic [LEN_W-1:0] len_q;
  logic [7:0]       win_q [WIN_BYTES];

  // check stage
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] span;
  logic [POS_W-1:0] last;
  logic [LEN_W-1:0] len;
  logic             chk_err;
  logic [POS_W:0]   app_end;
  logic [WIN_W-1:0] sh;

  // run and finish
  logic             is_read_op;
  logic             issue;
  logic [7:0]       set_mask;
  logic [WIN_W-1:0] rev;
  logic [WIN_W-1:0] rev_sh;
  logic [63:0]      len_mask;
  logic [63:0]      slice_val;
  logic [POS_W-1:0] fill_new;

  always_comb begin
    pos     = (it_q.action == ACT_APPEND) ? fill_q : {1'b0, it_q.bit_pos};
    span    = it_q.slice_end - {1'b0, it_q.bit_pos};
    app_end = {1'b0, fill_q} + (POS_W+1)'(it_q.width);
    unique case (it_q.action) inside
      ACT_APPEND: begin
        len     = it_q.width;
        chk_err = (it_q.width == '0) || (it_q.width > LEN_W'(MAX_FIELD_BITS)) ||
                  (app_end > {1'b0, limit_i});
      end
      ACT_SET, ACT_GET: begin
        len     = LEN_W'(1);
        chk_err = ({1'b0, it_q.bit_pos} >= limit_i);
      end
      default: begin
        len     = span[LEN_W-1:0];
        chk_err = (it_q.slice_end <= {1'b0, it_q.bit_pos}) ||
                  (it_q.slice_end > limit_i) || (span > POS_W'(SLICE_MAX));
      end
    endcase
    last = pos + POS_W'(len) - POS_W'(1);
    // field MSB lands at window bit 71, then moves right by the bit offset
    sh = {it_q.value, 8'h00} << (LEN_W'(64) - it_q.width);
    sh = sh >> pos[2:0];
  end

  assign is_read_op = (it_q.action == ACT_GET) || (it_q.action == ACT_SLICE);
  assign issue      = (j_q <= nbytes_q);
  assign set_mask   = 8'h80 >> off_q;

  always_comb begin
    for (int b = 0; b < WIN_BYTES; b++) begin
      for (int k = 0; k < 8; k++) begin
        rev[8*b + k] = win_q[b][7-k];
      end
    end
    rev_sh    = rev >> off_q;
    len_mask  = ~64'd0 >> (LEN_W'(64) - len_q);
    slice_val = rev_sh[63:0] & len_mask;
    fill_new  = (it_q.action == ACT_APPEND && !err_q) ? fill_q + POS_W'(len_q) : fill_q;
  end

  always_comb begin
    res_o.read_value = (it_q.action == ACT_SLICE) ? (err_q ? '1 : slice_val) : '0;
    res_o.bit_out    = (it_q.action == ACT_GET && !err_q) ? win_q[0][3'd7 - off_q] : 1'b0;
    res_o.fill_out   = fill_new;
    res_o.error      = err_q;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    j_d          = j_q;
    pj_d         = pj_q;
    pend_d       = 1'b0;
    fill_d       = fill_q;
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = AW'(first_q + CAP_W'(pj_q));
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = AW'(first_q + CAP_W'(j_q));
    unique case (state_q)
      S_CLR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        if (clr_q == AW'(BUFFER_BYTES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        j_d     = '0;
        state_d = chk_err ? S_FIN : S_RUN;
      end
      S_RUN: begin
        if (issue) begin
          mem_re_o = 1'b1;
          j_d      = j_q + CNT_W'(1);
          pend_d   = 1'b1;
          pj_d     = j_q;
        end
        // read data for byte pj arrives while the next byte is being read
        if (pend_q && !is_read_op) begin
          mem_we_o = 1'b1;
          if (it_q.action == ACT_APPEND) begin
            mem_wdata_o = mem_rdata_i | win_q[pj_q];
          end else begin
            mem_wdata_o = it_q.bit_value ? (mem_rdata_i | set_mask)
                                         : (mem_rdata_i & ~set_mask);
          end
        end
        if (!issue && !pend_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          fill_d  = fill_new;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      j_q     <= '0;
      pj_q    <= '0;
      pend_q  <= 1'b0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      j_q     <= j_d;
      pj_q    <= pj_d;
      pend_q  <= pend_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && item_valid_i) begin
      it_q <= item_i;
    end
    if (state_q == S_CHECK) begin
      err_q    <= chk_err;
      first_q  <= pos[POS_W-1:3];
      nbytes_q <= CNT_W'(last[POS_W-1:3] - pos[POS_W-1:3]);
      off_q    <= pos[2:0];
      len_q    <= len;
      for (int b = 0; b < WIN_BYTES; b++) begin
        win_q[b] <= sh[WIN_W-1-8*b -: 8];
      end
    end
    if (state_q == S_RUN && pend_q && is_read_op) begin
      win_q[pj_q] <= mem_rdata_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_only_on_modify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && state_q == S_RUN) |->
      (it_q.action == ACT_APPEND || it_q.action == ACT_SET))
    else $error("store written by a read request");

  a_pend_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_RUN))
    else $error("read data pending outside byte loop");

  a_no_same_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write hit the same byte in one cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (j_q <= nbytes_q + CNT_W'(1)))
    else $error("byte counter ran past the span");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && it_q.action == ACT_APPEND && !err_q) |-> (fill_new <= limit_i))
    else $error("append moved fill beyond capacity");
`endif

endmodule

// File: hdl/bit_packing_buffer_unit.sv
// Bit packing buffer top level: capacity register, sequencer, byte store, result register.
//
// Requests enter on item_i (valid/ready) and each gives exactly one result beat on
// result_o. Actions: append a 1 to 64 bit field MSB first at the fill position,
// set one bit, get one bit, or read a slice of up to 64 bits (first bit in LSB).
// cfg_we_i/cfg_wdata_i write the capacity in bytes; write it only while idle.
//
// After reset the byte store is swept to zero, one byte a cycle; item_i.ready stays
// low during the sweep. An item touching N bytes (N = 1..9) passes a check state,
// then a byte loop over the single byte-wide memory port, one byte per cycle, then a
// finish state that shows its result; a rejected request skips the byte loop. The next
// item is accepted only once the previous one has handed over its result.
// Results sit in an output register, so a new item is accepted while a result waits;
// if the receiver stalls, that item finishes and holds until the register frees up.
module bit_packing_buffer_unit #(
  parameter int BUFFER_BYTES = bpb_pkg::BUFFER_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bpb_item_if.sink                    item_i,
  bpb_result_if.source                result_o,
  input  logic                        cfg_we_i,
  input  logic [bpb_pkg::CAP_W-1:0]   cfg_wdata_i
);
  import bpb_pkg::*;

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  logic [CAP_W-1:0] cap_q;
  logic [CAP_W-1:0] cap_min;
  logic [POS_W-1:0] limit;

  logic             res_valid;
  logic             res_ready;
  bpb_result_t      res;
  logic             out_valid_q;
  bpb_result_t      out_data_q;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // capacity beyond the store acts as the store size
  assign cap_min = ((POS_W+1)'(cap_q) > (POS_W+1)'(BUFFER_BYTES)) ? CAP_W'(BUFFER_BYTES)
                                                                 : cap_q;
  assign limit   = {cap_min, 3'b000};

  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  bpb_engine #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .item_i       (item_i.data),
    .limit_i      (limit),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  bpb_mem #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: sim/bit_packing_buffer_unit_tb.sv
// Self-checking testbench for the bit packing buffer: directed and random requests vs. a store model.
`timescale 1ns / 100ps

module bit_packing_buffer_unit_tb;
  import bpb_pkg::*;

  // Tracks the byte store, fill and capacity, and queues the expected result of each request.
  class packer_scoreboard;
    bit [7:0]       store_bytes [BUFFER_BYTES_DEF];
    int unsigned    fill_bits;
    bit [CAP_W-1:0] capacity;
    bpb_result_t    expected_beats [$];
    int unsigned    mismatches;

    function new();
      fill_bits  = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
      foreach (store_bytes[i]) store_bytes[i] = 8'h00;
    endfunction

    function void set_capacity(bit [CAP_W-1:0] bytes);
      capacity = bytes;
    endfunction

    function int unsigned limit_bits();
      int unsigned c;
      c = capacity;
      if (c > BUFFER_BYTES_DEF) c = BUFFER_BYTES_DEF;
      return c * 8;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // bit 0 is the MSB of byte 0
    function bit peek_bit(int unsigned pos);
      if ((pos >> 3) >= BUFFER_BYTES_DEF) return 1'b0;
      return store_bytes[pos >> 3][7 - (pos & 7)];
    endfunction

    function void poke_bit(int unsigned pos, bit b);
      if ((pos >> 3) < BUFFER_BYTES_DEF) store_bytes[pos >> 3][7 - (pos & 7)] = b;
    endfunction

    function void note_request(bpb_item_t req);
      bpb_result_t want;
      int unsigned limit, w, start, stop, k;
      limit = limit_bits();
      w     = req.width;
      start = req.bit_pos;
      stop  = req.slice_end;
      want  = '0;
      case (req.action)
        ACT_APPEND: begin
          if (w == 0 || w > MAX_FIELD_BITS || fill_bits + w > limit) begin
            want.error = 1'b1;
          end else begin
            // OR only: ones written beyond the fill survive
            for (k = 0; k < w; k++)
              if (req.value[w - 1 - k]) poke_bit(fill_bits + k, 1'b1);
            fill_bits += w;
          end
        end
        ACT_SET: begin
          if (start >= limit) want.error = 1'b1;
          else poke_bit(start, req.bit_value);
        end
        ACT_GET: begin
          if (start >= limit) want.error = 1'b1;
          else want.bit_out = peek_bit(start);
        end
        ACT_SLICE: begin
          if (stop > start && stop <= limit && stop - start <= SLICE_MAX) begin
            for (k = 0; k < stop - start; k++) want.read_value[k] = peek_bit(start + k);
          end else begin
            want.error      = 1'b1;
            want.read_value = '1;
          end
        end
      endcase
      want.fill_out = POS_W'(fill_bits);
      expected_beats.push_back(want);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_beat(bpb_result_t got);
      bpb_result_t want;
      if (expected_beats.size() == 0) begin
        report("unrequested result beat", '0, got.read_value);
        return;
      end
      want = expected_beats.pop_front();
      if (got.read_value !== want.read_value) report("read_value", want.read_value, got.read_value);
      if (got.bit_out !== want.bit_out) report("bit_out", want.bit_out, got.bit_out);
      if (got.fill_out !== want.fill_out) report("fill_out", want.fill_out, got.fill_out);
      if (got.error !== want.error) report("error", want.error, got.error);
    endfunction
  endclass

  localparam int unsigned RANDOM_ITEMS = 1150;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  bpb_item_if   item_bus ();
  bpb_result_if result_bus ();

  packer_scoreboard packer = new();

  bit          src_quiet;
  bit          snk_quiet;
  int unsigned sink_hold;

  bit_packing_buffer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("bit_packing_buffer_unit test failed");
    $finish;
  end

  function automatic bpb_item_t directed_req(logic [1:0] act, logic [63:0] val, int unsigned w,
                                             bit b, int unsigned idx, int unsigned stop);
    bpb_item_t req;
    req.action    = act;
    req.value     = val;
    req.width     = LEN_W'(w);
    req.bit_value = b;
    req.bit_pos   = 16'(idx);
    req.slice_end = POS_W'(stop);
    return req;
  endfunction

  function automatic bpb_item_t random_request();
    bpb_item_t   req;
    int unsigned pick, limit, start, len;
    limit         = packer.limit_bits();
    req.value     = {$urandom, $urandom};
    req.width     = LEN_W'($urandom_range(0, 127));
    req.bit_value = 1'($urandom_range(0, 1));
    req.bit_pos   = 16'($urandom_range(0, 65535));
    req.slice_end = POS_W'($urandom_range(0, 131071));
    pick = $urandom_range(0, 99);
    if (pick < 35) req.action = ACT_APPEND;
    else if (pick < 55) req.action = ACT_SET;
    else if (pick < 75) req.action = ACT_GET;
    else req.action = ACT_SLICE;
    pick = $urandom_range(0, 9);
    if (req.action == ACT_APPEND) begin
      if (pick < 7) req.width = LEN_W'($urandom_range(1, 64));
      else if (pick < 9) req.width = LEN_W'(64);
    end else if (pick < 9) begin
      // position near the fill, at the capacity edge, or anywhere inside the capacity
      if (pick < 4)
        start = (packer.fill_bits > 64 ? packer.fill_bits - 64 : 0) + $urandom_range(0, 127);
      else if (pick < 6)
        start = (limit > 3 ? limit - 3 : 0) + $urandom_range(0, 4);
      else
        start = (limit != 0) ? $urandom_range(0, limit - 1) : 0;
      if (start > 65535) start = 65535;
      pick = $urandom_range(0, 9);
      if (pick < 8) len = $urandom_range(1, 64);
      else if (pick == 8) len = $urandom_range(65, 72);
      else len = 0;
      req.bit_pos   = 16'(start);
      req.slice_end = POS_W'(start + len);
    end
    return req;
  endfunction

  function automatic bit [CAP_W-1:0] pick_capacity(int unsigned phase);
    case (phase % 6)
      0: return CAP_RESET;
      1: return CAP_W'((packer.fill_bits >> 3) + $urandom_range(0, 12));
      2: return CAP_W'($urandom_range(1, 8191));
      3: return ($urandom_range(0, 1) != 0) ? '1 : CAP_W'($urandom_range(8193, 16383));
      4: return '0;
      default: return CAP_W'((packer.fill_bits >> 3) + $urandom_range(1, 3));
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_item(input bpb_item_t req);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.data  <= req;
    do @(posedge clk_i); while (!item_bus.ready);
    packer.note_request(req);
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    do @(posedge clk_i); while (packer.pending() != 0);
  endtask

  task automatic load_capacity(input bit [CAP_W-1:0] bytes);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bytes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    packer.set_capacity(bytes);
  endtask

  initial begin : result_sink
    int unsigned stall;
    result_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_quiet ? 0 : $urandom_range(0, 18);
      if (sink_hold != 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end
      if (stall != 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
      packer.check_beat(result_bus.data);
    end
  end

  initial begin : stimulus
    int unsigned phase, n, i, total;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    item_bus.valid = 1'b0;
    item_bus.data  = '0;
    src_quiet      = 1'b0;
    snk_quiet      = 1'b0;
    sink_hold      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one byte of capacity: fill it exactly, then overrun
    load_capacity(CAP_W'(1));
    send_item(directed_req(ACT_APPEND, 64'h15, 5, 1'b0, 0, 0));
    send_item(directed_req(ACT_APPEND, '1, 4, 1'b0, 0, 0));
    send_item(directed_req(ACT_APPEND, '1, 3, 1'b0, 0, 0));
    send_item(directed_req(ACT_GET, '0, 0, 1'b0, 8, 0));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 0, 8));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 0, 9));

    // zero capacity rejects everything
    load_capacity('0);
    send_item(directed_req(ACT_APPEND, '1, 1, 1'b0, 0, 0));
    send_item(directed_req(ACT_SET, '0, 0, 1'b1, 0, 0));
    send_item(directed_req(ACT_GET, '0, 0, 1'b0, 0, 0));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 0, 1));

    // register above the store size is clamped to the full store
    load_capacity('1);
    send_item(directed_req(ACT_APPEND, '1, 0, 1'b0, 0, 0));
    send_item(directed_req(ACT_APPEND, '1, 127, 1'b0, 0, 0));
    send_item(directed_req(ACT_APPEND, '1, 65, 1'b0, 0, 0));
    send_item(directed_req(ACT_APPEND, '1, 64, 1'b0, 0, 0));
    send_item(directed_req(ACT_SET, '0, 0, 1'b1, 80, 0));
    send_item(directed_req(ACT_APPEND, '0, 16, 1'b0, 0, 0));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 72, 88));
    send_item(directed_req(ACT_SET, '0, 0, 1'b1, 65535, 0));
    send_item(directed_req(ACT_GET, '0, 0, 1'b0, 65535, 0));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 65472, 65536));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 65535, 131071));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 10, 10));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 20, 10));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 0, 65));
    send_item(directed_req(ACT_SLICE, '0, 0, 1'b0, 0, 64));
    send_item(directed_req(ACT_SET, '0, 0, 1'b0, 0, 0));
    send_item(directed_req(ACT_GET, '0, 0, 1'b0, 0, 0));

    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      load_capacity(pick_capacity(phase));
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      n = (phase % 6 == 4) ? 12 : $urandom_range(60, 140);
      if (n > RANDOM_ITEMS - total) n = RANDOM_ITEMS - total;
      for (i = 0; i < n; i++) begin
        // long sink stall with the source still pushing, so the input backs up
        if (phase == 2 && i == 20) sink_hold = 400;
        if (phase == 3 && i == 40) drain();
        send_item(random_request());
      end
      total += n;
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (packer.mismatches == 0 && packer.pending() == 0) begin
      $display("bit_packing_buffer_unit test passed");
    end else begin
      $display("bit_packing_buffer_unit test failed");
    end
    $finish;
  end

endmodule
